// ----- rtl/core/tmqs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmqs_pkg
// shared types, codes and reset values of the timed message queue scheduler
// ----------------------------------------------------------------------------
package tmqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // request codes
    localparam logic [2:0] REQ_POST     = 3'd0;
    localparam logic [2:0] REQ_TICK     = 3'd1;
    localparam logic [2:0] REQ_ASK      = 3'd2;
    localparam logic [2:0] REQ_COMPLETE = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;
    localparam logic [2:0] REQ_DRAW     = 3'd5;

    // shown source codes
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_HEAD    = 2'd1;
    localparam logic [1:0] SRC_REQUEST = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_READ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_CHAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_READ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SHOWN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUED_READ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_AGE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_GRACE  = 3'd6;

    // register reset values
    localparam logic [9:0]  MIN_READ_RST    = 10'd90;
    localparam logic [3:0]  PER_CHAR_RST    = 4'd3;
    localparam logic [9:0]  MAX_READ_RST    = 10'd300;
    localparam logic [9:0]  MIN_SHOWN_RST   = 10'd60;
    localparam logic [9:0]  QUEUED_READ_RST = 10'd180;
    localparam logic [15:0] STALE_AGE_RST   = 16'd900;
    localparam logic [9:0]  SKIP_GRACE_RST  = 10'd30;

    typedef struct packed {
        logic [9:0]  min_read;
        logic [3:0]  per_char;
        logic [9:0]  max_read;
        logic [9:0]  min_shown;
        logic [9:0]  queued_read;
        logic [15:0] stale_age;
        logic [9:0]  skip_grace;
    } cfg_regs_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [9:0]  chars;
        logic [31:0] stamp;
    } entry_t;

endpackage
`default_nettype wire

// ----- rtl/core/tmqs_cmd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmqs_cmd_if
// request channel: one request word per handshake
// ----------------------------------------------------------------------------
interface tmqs_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] msg_tag;
    logic [9:0]  text_chars;
    logic [3:0]  task_id;
    logic        skip_press;

    modport source (output valid, req_type, msg_tag, text_chars, task_id, skip_press,
                    input ready);
    modport sink (input valid, req_type, msg_tag, text_chars, task_id, skip_press,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tmqs_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmqs_rsp_if
// result channel: one display status word per handshake
// ----------------------------------------------------------------------------
interface tmqs_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  shown_source;
    logic [15:0] shown_tag;
    logic [3:0]  shown_task;
    logic [3:0]  waiting_count;
    logic [9:0]  remaining_frames;
    logic        redraw;

    modport source (output valid, shown_source, shown_tag, shown_task, waiting_count,
                    remaining_frames, redraw, input ready);
    modport sink (input valid, shown_source, shown_tag, shown_task, waiting_count,
                  remaining_frames, redraw, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tmqs_cfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmqs_cfg_if
// register write channel: one index and data word per handshake
// ----------------------------------------------------------------------------
interface tmqs_cfg_if;
    import tmqs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/timed_message_queue_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timed_message_queue_scheduler
// bounded queue of timed messages with dwell, skip, staleness and request slot
// ----------------------------------------------------------------------------
// Requests arrive one word at a time on cmd and each returns exactly one status
// word on rsp. The block works on one request at a time. Queue entries (tag,
// character count, post frame) live in one synchronous memory with a registered
// read; the head's tag is also held in a register so that status needs no read.
// Path from accept to a result in the output register: ask, complete, clear,
// draw and unused codes execute and finish; a post also passes a write state,
// preceded by the compaction walk when the queue is full; a tick on an empty
// queue only executes, otherwise it runs the stale walk when others wait, a
// decision, a head load when the advance loads a new head and a dwell cut when
// others wait behind it. The walk streams one memory entry per cycle (read next
// entry, write kept entry back), so the queue depth sets the worst case. The
// output is registered: a new request is accepted as soon as the last result is
// taken or in the same cycle. Register writes are always accepted and take
// effect at once; they belong in idle periods. The memory has no reset: an
// entry is only read after it has been written.
// ----------------------------------------------------------------------------
module timed_message_queue_scheduler
    import tmqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    tmqs_cmd_if.sink    cmd,
    tmqs_rsp_if.source  rsp,
    tmqs_cfg_if.sink    cfg
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_POST,
        S_DECIDE,
        S_HEAD,
        S_SHORT,
        S_DONE
    } state_t;

    // physical slot of queue position off, counted from the head
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
            s = s - SUM_W'(QUEUE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    state_t             state_reg;
    cfg_regs_t          cfg_reg;

    // latched request word
    logic [2:0]         op_reg;
    logic [15:0]        tag_reg;
    logic [9:0]         chars_reg;
    logic [3:0]         task_reg;
    logic               skip_reg;

    // scheduler state
    logic [IDX_W-1:0]   head_idx_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic signed [10:0] dwell_reg;
    logic [10:0]        shown_reg;
    logic [31:0]        frame_reg;
    logic [15:0]        req_tag_reg;
    logic [3:0]         req_task_reg;
    logic               req_valid_reg;
    logic               dirty_reg;
    logic [15:0]        head_tag_reg;

    // compaction walk
    logic [CNT_W-1:0]   walk_j_reg;
    logic [CNT_W-1:0]   kept_reg;
    logic               drop_mode_reg;

    // output register
    logic               rsp_valid_reg;
    logic [1:0]         rsp_src_reg;
    logic [15:0]        rsp_tag_reg;
    logic [3:0]         rsp_task_reg;
    logic [3:0]         rsp_count_reg;
    logic [9:0]         rsp_rem_reg;
    logic               rsp_redraw_reg;

    // entry memory
    entry_t             mem [QUEUE_DEPTH];
    entry_t             rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_wdata;

    // derived control
    logic               cmd_fire;
    logic               queue_full;
    logic               walk_last;
    logic               walk_keep;
    logic [CNT_W-1:0]   kept_next;
    logic [31:0]        entry_age;
    logic               dwell_pos;
    logic               advance;
    logic [9:0]         chars_sel;
    logic signed [10:0] start_dwell;
    logic signed [10:0] short_dwell;
    logic [1:0]         res_src;
    logic [15:0]        res_tag;
    logic [3:0]         res_task;
    logic [CNT_W+3:0]   fill_wide;

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cfg.ready  = 1'b1;
    assign queue_full = (fill_reg == CNT_W'(QUEUE_DEPTH));

    // walk: position 1 goes when dropping the oldest, else stale entries go
    assign entry_age = frame_reg - rd_data_reg.stamp;
    assign walk_keep = drop_mode_reg ? (walk_j_reg != CNT_W'(1))
                                     : !(entry_age > {16'b0, cfg_reg.stale_age});
    assign kept_next = kept_reg + CNT_W'(walk_keep);
    assign walk_last = (SUM_W'(walk_j_reg) + SUM_W'(1)) >= SUM_W'(fill_reg);

    // expiry, or a skip after the grace period
    assign dwell_pos = !dwell_reg[10] && (dwell_reg != 11'sd0);
    assign advance   = !dwell_pos || (skip_reg && (shown_reg >= {1'b0, cfg_reg.skip_grace}));

    assign chars_sel = (state_reg == S_HEAD) ? rd_data_reg.chars : chars_reg;

    tmqs_dwell u_dwell (
        .cfg         (cfg_reg),
        .chars       (chars_sel),
        .shown       (shown_reg),
        .dwell       (dwell_reg),
        .start_dwell (start_dwell),
        .short_dwell (short_dwell)
    );

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = slot(head_idx_reg, kept_reg);
        mem_raddr = slot(head_idx_reg, CNT_W'(1));
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                // first read of a walk
                if ((op_reg == REQ_POST && queue_full) ||
                    (op_reg == REQ_TICK && fill_reg > CNT_W'(1)))
                    mem_re = 1'b1;
            end
            S_WALK:
            begin
                // write back kept entry while the next one is read
                mem_we = walk_keep && (kept_reg != walk_j_reg);
                if (!walk_last)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(head_idx_reg, walk_j_reg + CNT_W'(1));
                end
            end
            S_POST:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot(head_idx_reg, fill_reg);
                mem_wdata = '{tag: tag_reg, chars: chars_reg, stamp: frame_reg};
            end
            S_DECIDE:
            begin
                // fetch the next head
                mem_re = advance && (fill_reg > CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // status taken after the update
    assign fill_wide = {4'b0, fill_reg};
    always_comb
    begin
        res_src  = SRC_NONE;
        res_tag  = 16'd0;
        res_task = 4'd0;
        if (fill_reg != '0)
        begin
            res_src = SRC_HEAD;
            res_tag = head_tag_reg;
        end
        else if (req_valid_reg)
        begin
            res_src  = SRC_REQUEST;
            res_tag  = req_tag_reg;
            res_task = req_task_reg;
        end
    end

    // request word and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            op_reg    <= cmd.req_type;
            tag_reg   <= cmd.msg_tag;
            chars_reg <= cmd.text_chars;
            task_reg  <= cmd.task_id;
            skip_reg  <= cmd.skip_press;
        end
        if (state_reg == S_DONE)
        begin
            rsp_src_reg    <= res_src;
            rsp_tag_reg    <= res_tag;
            rsp_task_reg   <= res_task;
            rsp_count_reg  <= fill_wide[3:0];
            rsp_rem_reg    <= dwell_pos ? dwell_reg[9:0] : 10'd0;
            rsp_redraw_reg <= dirty_reg;
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_read    <= MIN_READ_RST;
            cfg_reg.per_char    <= PER_CHAR_RST;
            cfg_reg.max_read    <= MAX_READ_RST;
            cfg_reg.min_shown   <= MIN_SHOWN_RST;
            cfg_reg.queued_read <= QUEUED_READ_RST;
            cfg_reg.stale_age   <= STALE_AGE_RST;
            cfg_reg.skip_grace  <= SKIP_GRACE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                CFG_MIN_READ:    cfg_reg.min_read    <= cfg.wr_data[9:0];
                CFG_PER_CHAR:    cfg_reg.per_char    <= cfg.wr_data[3:0];
                CFG_MAX_READ:    cfg_reg.max_read    <= cfg.wr_data[9:0];
                CFG_MIN_SHOWN:   cfg_reg.min_shown   <= cfg.wr_data[9:0];
                CFG_QUEUED_READ: cfg_reg.queued_read <= cfg.wr_data[9:0];
                CFG_STALE_AGE:   cfg_reg.stale_age   <= cfg.wr_data[15:0];
                CFG_SKIP_GRACE:  cfg_reg.skip_grace  <= cfg.wr_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_idx_reg  <= '0;
            fill_reg      <= '0;
            dwell_reg     <= 11'sd0;
            shown_reg     <= '0;
            frame_reg     <= '0;
            req_tag_reg   <= '0;
            req_task_reg  <= '0;
            req_valid_reg <= 1'b0;
            dirty_reg     <= 1'b0;
            head_tag_reg  <= '0;
            walk_j_reg    <= '0;
            kept_reg      <= '0;
            drop_mode_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    unique case (op_reg)
                        REQ_POST:
                        begin
                            if (queue_full)
                            begin
                                walk_j_reg    <= CNT_W'(1);
                                kept_reg      <= CNT_W'(1);
                                drop_mode_reg <= 1'b1;
                                state_reg     <= S_WALK;
                            end
                            else
                                state_reg <= S_POST;
                        end
                        REQ_TICK:
                        begin
                            frame_reg <= frame_reg + 32'd1;
                            if (fill_reg != '0)
                            begin
                                if (shown_reg != 11'h7FF)
                                    shown_reg <= shown_reg + 11'd1;
                                dwell_reg <= dwell_reg - 11'sd1;
                                if (fill_reg > CNT_W'(1))
                                begin
                                    walk_j_reg    <= CNT_W'(1);
                                    kept_reg      <= CNT_W'(1);
                                    drop_mode_reg <= 1'b0;
                                    state_reg     <= S_WALK;
                                end
                                else
                                    state_reg <= S_DECIDE;
                            end
                        end
                        REQ_ASK:
                        begin
                            req_tag_reg   <= tag_reg;
                            req_task_reg  <= task_reg;
                            req_valid_reg <= 1'b1;
                            if (fill_reg == '0)
                                dirty_reg <= 1'b1;
                        end
                        REQ_COMPLETE:
                        begin
                            if (req_valid_reg && req_task_reg == task_reg)
                            begin
                                req_valid_reg <= 1'b0;
                                if (fill_reg == '0)
                                    dirty_reg <= 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fill_reg      <= '0;
                            dwell_reg     <= 11'sd0;
                            shown_reg     <= '0;
                            req_valid_reg <= 1'b0;
                            dirty_reg     <= 1'b1;
                        end
                        REQ_DRAW:
                        begin
                            dirty_reg <= 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_WALK:
                begin
                    kept_reg   <= kept_next;
                    walk_j_reg <= walk_j_reg + CNT_W'(1);
                    if (walk_last)
                    begin
                        fill_reg  <= kept_next;
                        state_reg <= drop_mode_reg ? S_POST : S_DECIDE;
                    end
                end
                S_POST:
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                    if (fill_reg == '0)
                    begin
                        head_tag_reg <= tag_reg;
                        dwell_reg    <= start_dwell;
                        shown_reg    <= '0;
                        dirty_reg    <= 1'b1;
                    end
                    else
                        dwell_reg <= short_dwell;
                    state_reg <= S_DONE;
                end
                S_DECIDE:
                begin
                    if (advance)
                    begin
                        head_idx_reg <= slot(head_idx_reg, CNT_W'(1));
                        fill_reg     <= fill_reg - CNT_W'(1);
                        if (fill_reg > CNT_W'(1))
                            state_reg <= S_HEAD;
                        else
                        begin
                            // queue ran empty
                            dwell_reg <= 11'sd0;
                            shown_reg <= '0;
                            dirty_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_HEAD:
                begin
                    head_tag_reg <= rd_data_reg.tag;
                    dwell_reg    <= start_dwell;
                    shown_reg    <= '0;
                    dirty_reg    <= 1'b1;
                    state_reg    <= (fill_reg > CNT_W'(1)) ? S_SHORT : S_DONE;
                end
                S_SHORT:
                begin
                    dwell_reg <= short_dwell;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.shown_source     = rsp_src_reg;
    assign rsp.shown_tag        = rsp_tag_reg;
    assign rsp.shown_task       = rsp_task_reg;
    assign rsp.waiting_count    = rsp_count_reg;
    assign rsp.remaining_frames = rsp_rem_reg;
    assign rsp.redraw           = rsp_redraw_reg;

    // checks

    // fill never exceeds the queue
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // a streaming walk never writes the entry it reads in the same cycle
    a_walk_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("memory read and write hit the same entry");

    // between requests the dwell is never negative
    a_dwell_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !dwell_reg[10])
        else $error("negative dwell left after a request");

    // each accepted request yields a result word
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> rsp_valid_reg)
        else $error("result word not presented");

endmodule
`default_nettype wire

// ----- rtl/core/tmqs_dwell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmqs_dwell
// dwell arithmetic: start value of a new head and the cut while others wait
// ----------------------------------------------------------------------------
module tmqs_dwell
    import tmqs_pkg::*;
(
    input  cfg_regs_t          cfg,
    input  logic [9:0]         chars,
    input  logic [10:0]        shown,
    input  logic signed [10:0] dwell,
    output logic signed [10:0] start_dwell,
    output logic signed [10:0] short_dwell
);

    logic [13:0]        prod;
    logic [14:0]        sum;
    logic signed [12:0] shown_s;
    logic signed [12:0] least_raw;
    logic signed [12:0] least;
    logic signed [12:0] most_raw;
    logic signed [12:0] most;
    logic signed [12:0] dwell_s;

    // min(min_read + per_char * chars, max_read)
    assign prod = cfg.per_char * chars;
    assign sum  = {5'b0, cfg.min_read} + {1'b0, prod};
    assign start_dwell = (sum > {5'b0, cfg.max_read}) ? $signed({1'b0, cfg.max_read})
                                                      : $signed({1'b0, sum[9:0]});

    // keep at least min_shown, linger at most queued_read in all
    assign shown_s   = $signed({2'b00, shown});
    assign least_raw = $signed({3'b000, cfg.min_shown}) - shown_s;
    assign least     = least_raw[12] ? 13'sd0 : least_raw;
    assign most_raw  = $signed({3'b000, cfg.queued_read}) - shown_s;
    assign most      = (most_raw < least) ? least : most_raw;
    assign dwell_s   = $signed({{2{dwell[10]}}, dwell});
    assign short_dwell = (dwell_s > most) ? most[10:0] : dwell;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the timed message queue scheduler
// ----------------------------------------------------------------------------
// Request words go in on cmd and the display status words that come back on
// rsp are checked against an in-bench predictor of the scheduler: queue with
// drop-oldest overflow, dwell and its cut while others wait, stale compaction,
// skip after grace, request slot and redraw flag. Named tests run directed
// corner cases, then random traffic under several register settings (zero and
// all-ones limits among them), a long receiver hold-off and a last stretch with
// no idling on either side.
// ----------------------------------------------------------------------------
module tb;
    import tmqs_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int SHOWN_CAP   = 2047;
    localparam int REM_CAP     = 1023;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // request codes the block does not use; they still return a status word
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam cfg_regs_t DEFAULT_REGS = '{MIN_READ_RST, PER_CHAR_RST, MAX_READ_RST,
                                           MIN_SHOWN_RST, QUEUED_READ_RST,
                                           STALE_AGE_RST, SKIP_GRACE_RST};

    // one display status word
    typedef struct packed {
        logic [1:0]  src;
        logic [15:0] tag;
        logic [3:0]  task_no;
        logic [3:0]  count;
        logic [9:0]  rem;
        logic        redraw;
    } status_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tmqs_cmd_if cmd_bus();
    tmqs_rsp_if rsp_bus();
    tmqs_cfg_if cfg_bus();

    timed_message_queue_scheduler #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    // 4 unit clock period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor state: its own copy of queue, timers, request slot and regs
    // ------------------------------------------------------------------------
    cfg_regs_t   regs;
    logic [15:0] q_tag   [DEPTH];
    logic [9:0]  q_chars [DEPTH];
    logic [31:0] q_stamp [DEPTH];
    int          head_ptr;
    int          fill;
    int          dwell;       // signed, may go below zero on the expiring tick
    int          shown_cnt;
    logic [31:0] frame_no;
    logic [15:0] slot_tag;
    logic [3:0]  slot_task;
    logic        slot_held;
    logic        dirty;

    // expected status words, oldest first
    status_t pending_status[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  hold_left   = 0;     // receiver hold-off, counted down by the receiver
    bit  jitter_on   = 1'b1;  // random idle bursts on both sides
    bit  allow_idle  = 1'b1;  // cleared for the last stretch of the run

    // ring position of the entry at offset off from the head
    function automatic int pos(int off);
        return (head_ptr + off) % DEPTH;
    endfunction

    function automatic void move_entry(int dst, int from);
        q_tag[dst]   = q_tag[from];
        q_chars[dst] = q_chars[from];
        q_stamp[dst] = q_stamp[from];
    endfunction

    // fresh head: dwell from base plus per-character, capped
    function automatic void load_head();
        int base;
        int per;
        int cap;
        int nchar;
        int f;
        base  = regs.min_read;
        per   = regs.per_char;
        cap   = regs.max_read;
        nchar = q_chars[pos(0)];
        f     = base + per * nchar;
        if (f > cap)
            f = cap;
        dwell     = f;
        shown_cnt = 0;
        dirty     = 1'b1;
    endfunction

    // others waiting: keep at least min_shown in all, at most queued_read in all
    function automatic void cut_head();
        int least;
        int most;
        least = int'(regs.min_shown) - shown_cnt;
        if (least < 0)
            least = 0;
        most = int'(regs.queued_read) - shown_cnt;
        if (most < least)
            most = least;
        if (dwell > most)
            dwell = most;
    endfunction

    // full queue: the entry right behind the head goes, the head stays
    function automatic void drop_oldest_waiting();
        int i;
        if (fill < 2)
            return;
        for (i = 1; i + 1 < fill; i++)
            move_entry(pos(i), pos(i + 1));
        fill--;
    endfunction

    // compact waiting entries, dropping those older than stale_age (mod 2^32)
    function automatic void drop_stale_waiting();
        int          kept;
        int          i;
        int          p;
        logic [31:0] age;
        logic [31:0] limit;
        kept  = 1;
        limit = regs.stale_age;
        for (i = 1; i < fill; i++)
        begin
            p   = pos(i);
            age = frame_no - q_stamp[p];
            if (age > limit)
                continue;
            if (kept != i)
                move_entry(pos(kept), p);
            kept++;
        end
        if (fill > 0)
            fill = kept;
    endfunction

    function automatic void advance_head();
        head_ptr = (head_ptr + 1) % DEPTH;
        fill--;
        if (fill > 0)
        begin
            load_head();
            if (fill > 1)
                cut_head();
        end
        else
        begin
            dwell     = 0;
            shown_cnt = 0;
            dirty     = 1'b1;
        end
    endfunction

    // apply one request word and return the status word it should produce
    function automatic status_t next_display_status(logic [2:0] kind, logic [15:0] tag,
                                                    logic [9:0] chars, logic [3:0] tid,
                                                    logic skip);
        status_t s;
        int      p;
        int      grace;
        s     = '0;
        grace = regs.skip_grace;
        case (kind)
            REQ_POST:
            begin
                if (fill >= DEPTH)
                    drop_oldest_waiting();
                p          = pos(fill);
                q_tag[p]   = tag;
                q_chars[p] = chars;
                q_stamp[p] = frame_no;
                fill++;
                if (fill == 1)
                    load_head();
                else
                    cut_head();
            end
            REQ_TICK:
            begin
                frame_no = frame_no + 32'd1;
                if (fill != 0)
                begin
                    if (shown_cnt < SHOWN_CAP)
                        shown_cnt++;
                    dwell--;
                    drop_stale_waiting();
                    if (!(dwell > 0 && !(skip && shown_cnt >= grace)))
                        advance_head();
                end
            end
            REQ_ASK:
            begin
                slot_tag  = tag;
                slot_task = tid;
                slot_held = 1'b1;
                if (fill == 0)
                    dirty = 1'b1;
            end
            REQ_COMPLETE:
            begin
                if (slot_held && slot_task == tid)
                begin
                    slot_held = 1'b0;
                    if (fill == 0)
                        dirty = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                // head_ptr is left where it was
                fill      = 0;
                dwell     = 0;
                shown_cnt = 0;
                slot_held = 1'b0;
                dirty     = 1'b1;
            end
            REQ_DRAW:
                dirty = 1'b0;
            default: ;
        endcase

        if (fill > 0)
        begin
            s.src = SRC_HEAD;
            s.tag = q_tag[pos(0)];
            if (dwell > 0)
                s.rem = (dwell > REM_CAP) ? 10'(REM_CAP) : 10'(dwell);
        end
        else if (slot_held)
        begin
            s.src     = SRC_REQUEST;
            s.tag     = slot_tag;
            s.task_no = slot_task;
        end
        else
            s.src = SRC_NONE;
        s.count  = 4'(fill);
        s.redraw = dirty;
        return s;
    endfunction

    task automatic reset_model();
        int i;
        regs = DEFAULT_REGS;
        for (i = 0; i < DEPTH; i++)
        begin
            q_tag[i]   = '0;
            q_chars[i] = '0;
            q_stamp[i] = '0;
        end
        head_ptr  = 0;
        fill      = 0;
        dwell     = 0;
        shown_cnt = 0;
        frame_no  = '0;
        slot_tag  = '0;
        slot_task = '0;
        slot_held = 1'b0;
        dirty     = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // register writes: valid stays up across a burst, lowered once at the end
    // ------------------------------------------------------------------------
    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wr_data   <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_MIN_READ:    regs.min_read    = data[9:0];
            CFG_PER_CHAR:    regs.per_char    = data[3:0];
            CFG_MAX_READ:    regs.max_read    = data[9:0];
            CFG_MIN_SHOWN:   regs.min_shown   = data[9:0];
            CFG_QUEUED_READ: regs.queued_read = data[9:0];
            CFG_STALE_AGE:   regs.stale_age   = data[15:0];
            CFG_SKIP_GRACE:  regs.skip_grace  = data[9:0];
            default: ;
        endcase
    endtask

    // only called with nothing in flight, so the block is idle
    task automatic load_settings(cfg_regs_t r);
        write_setting(CFG_MIN_READ,    r.min_read);
        write_setting(CFG_PER_CHAR,    r.per_char);
        write_setting(CFG_MAX_READ,    r.max_read);
        write_setting(CFG_MIN_SHOWN,   r.min_shown);
        write_setting(CFG_QUEUED_READ, r.queued_read);
        write_setting(CFG_STALE_AGE,   r.stale_age);
        write_setting(CFG_SKIP_GRACE,  r.skip_grace);
        cfg_bus.valid <= 1'b0;
    endtask

    // short timings so the queue turns over quickly
    function automatic cfg_regs_t quick_settings();
        cfg_regs_t r;
        r.min_read    = 10'($urandom_range(0, 8));
        r.per_char    = 4'($urandom_range(0, 2));
        r.max_read    = 10'($urandom_range(0, 20));
        r.min_shown   = 10'($urandom_range(0, 6));
        r.queued_read = 10'($urandom_range(0, 15));
        r.stale_age   = 16'($urandom_range(0, 40));
        r.skip_grace  = 10'($urandom_range(0, 6));
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    // send one request word; valid is left high so back-to-back words need no
    // second assignment in the same step; prediction is made at acceptance
    task automatic send_request(logic [2:0] kind, logic [15:0] tag, logic [9:0] chars,
                                logic [3:0] tid, logic skip);
        if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.req_type   <= kind;
        cmd_bus.msg_tag    <= tag;
        cmd_bus.text_chars <= chars;
        cmd_bus.task_id    <= tid;
        cmd_bus.skip_press <= skip;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        pending_status.push_back(next_display_status(kind, tag, chars, tid, skip));
    endtask

    // sender pauses until every status word owed has come back
    task automatic wait_results_done();
        cmd_bus.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    // one random request: tick heavy so heads expire, stale entries go and
    // skips land; completes mostly name the task that was asked
    task automatic random_request();
        logic [2:0]  kind;
        logic [15:0] tag;
        logic [9:0]  chars;
        logic [3:0]  tid;
        logic        skip;
        int          r;
        int          pick;
        tag   = 16'($urandom);
        chars = 10'($urandom);
        tid   = 4'($urandom);
        skip  = ($urandom_range(0, 3) == 0);
        r     = $urandom_range(0, 99);
        if (r < 28)
        begin
            kind = REQ_POST;
            pick = $urandom_range(0, 3);
            if (pick == 0)
                chars = '0;
            else if (pick == 1)
                chars = '1;
            else if (pick == 2)
                chars = 10'($urandom_range(0, 20));
        end
        else if (r < 78)
            kind = REQ_TICK;
        else if (r < 83)
            kind = REQ_ASK;
        else if (r < 88)
        begin
            kind = REQ_COMPLETE;
            if ($urandom_range(0, 9) < 7)
                tid = slot_task;
        end
        else if (r < 90)
            kind = REQ_CLEAR;
        else if (r < 97)
            kind = REQ_DRAW;
        else
            kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        send_request(kind, tag, chars, tid, skip);
    endtask

    // random words, idling switched on and off in stretches
    task automatic run_traffic(int n_items);
        int i;
        for (i = 0; i < n_items; i++)
        begin
            if (allow_idle && i % 50 == 0)
                jitter_on = ($urandom_range(0, 3) != 0);
            random_request();
        end
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // corner cases in a short fixed sequence
    task automatic test_directed_cases();
        cfg_regs_t r;
        int        i;
        r = '{min_read: 10'd4, per_char: 4'd1, max_read: 10'd10, min_shown: 10'd2,
              queued_read: 10'd6, stale_age: 16'd5, skip_grace: 10'd2};
        load_settings(r);
        // tick on an empty queue only ages the frame counter
        send_request(REQ_TICK, 16'h0000, 10'd0, 4'h0, 1'b0);
        // request slot shows while nothing is queued
        send_request(REQ_ASK, 16'hFFFF, 10'd0, 4'hF, 1'b0);
        send_request(REQ_DRAW, 16'h0000, 10'd0, 4'h0, 1'b0);
        // complete with the wrong task, the right one, then with no request held
        send_request(REQ_COMPLETE, 16'h0000, 10'd0, 4'h3, 1'b0);
        send_request(REQ_COMPLETE, 16'h0000, 10'd0, 4'hF, 1'b0);
        send_request(REQ_COMPLETE, 16'h0000, 10'd0, 4'hF, 1'b0);
        // field extremes on post; second post cuts the head's dwell
        send_request(REQ_POST, 16'h0000, 10'd0, 4'h0, 1'b0);
        send_request(REQ_POST, 16'hFFFF, 10'h3FF, 4'hF, 1'b1);
        // skip before and after the grace period
        send_request(REQ_TICK, 16'h0000, 10'd0, 4'h0, 1'b1);
        send_request(REQ_TICK, 16'h0000, 10'd0, 4'h0, 1'b1);
        // fill the queue and post past full: oldest waiting entry goes
        for (i = 0; i < DEPTH; i++)
            send_request(REQ_POST, 16'h1000 + 16'(i), 10'(i), 4'h0, 1'b0);
        // age the waiting entries past stale_age
        for (i = 0; i < 6; i++)
            send_request(REQ_TICK, 16'h0000, 10'd0, 4'h0, 1'b0);
        send_request(REQ_SPARE_A, 16'hFFFF, 10'h3FF, 4'hF, 1'b1);
        send_request(REQ_SPARE_B, 16'hFFFF, 10'h3FF, 4'hF, 1'b1);
        send_request(REQ_CLEAR, 16'h0000, 10'd0, 4'h0, 1'b0);
        wait_results_done();
    endtask

    // reset-value timings: long dwells, mostly skips and overflow
    task automatic test_default_timing();
        load_settings(DEFAULT_REGS);
        run_traffic(150);
    endtask

    // several random short timing settings
    task automatic test_quick_timing();
        int k;
        for (k = 0; k < 4; k++)
        begin
            load_settings(quick_settings());
            run_traffic(180);
        end
    endtask

    // all limits zero: every tick expires the head, any wait is stale
    task automatic test_zero_limits();
        load_settings('{default: '0});
        run_traffic(150);
    endtask

    // all limits at their top value: the head lingers, the queue overflows
    task automatic test_full_limits();
        load_settings('{default: '1});
        run_traffic(120);
    endtask

    // cap below base dwell and min_shown above queued_read
    task automatic test_crossed_limits();
        cfg_regs_t r;
        r = '{min_read: 10'd12, per_char: 4'd4, max_read: 10'd5, min_shown: 10'd9,
              queued_read: 10'd3, stale_age: 16'd8, skip_grace: 10'd4};
        load_settings(r);
        run_traffic(150);
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_receiver_hold();
        load_settings(quick_settings());
        hold_left = 150;
        run_traffic(40);
    endtask

    // last stretch with no idling on either side
    task automatic test_steady_stream();
        allow_idle = 1'b0;
        jitter_on  = 1'b0;
        load_settings(quick_settings());
        run_traffic(100);
    endtask

    // ------------------------------------------------------------------------
    // result side: ready with random stall bursts and the long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : status_receiver
        int stall_left;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (jitter_on && $urandom_range(0, 7) == 0)
            begin
                // random burst of stalled cycles
                rsp_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // compare every accepted status word with the oldest prediction
    initial
    begin : status_checker
        status_t want;
        status_t got;
        logic    bad;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                got.src     = rsp_bus.shown_source;
                got.tag     = rsp_bus.shown_tag;
                got.task_no = rsp_bus.shown_task;
                got.count   = rsp_bus.waiting_count;
                got.rem     = rsp_bus.remaining_frames;
                got.redraw  = rsp_bus.redraw;
                if (pending_status.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected status word: src %0d tag %h task %0d count %0d rem %0d redraw %0d",
                                 got.src, got.tag, got.task_no, got.count, got.rem, got.redraw);
                end
                else
                begin
                    want = pending_status.pop_front();
                    bad  = (got.src !== want.src) || (got.tag !== want.tag) ||
                           (got.task_no !== want.task_no) || (got.count !== want.count) ||
                           (got.rem !== want.rem) || (got.redraw !== want.redraw);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("status mismatch at cycle %0d", cycle_count);
                            $display("  expected: src %0d tag %h task %0d count %0d rem %0d redraw %0d",
                                     want.src, want.tag, want.task_no, want.count, want.rem,
                                     want.redraw);
                            $display("  actual:   src %0d tag %h task %0d count %0d rem %0d redraw %0d",
                                     got.src, got.tag, got.task_no, got.count, got.rem,
                                     got.redraw);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout: %0d status words still owed", pending_status.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_bus.valid      <= 1'b0;
        cmd_bus.req_type   <= REQ_POST;
        cmd_bus.msg_tag    <= '0;
        cmd_bus.text_chars <= '0;
        cmd_bus.task_id    <= '0;
        cmd_bus.skip_press <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.reg_index  <= CFG_MIN_READ;
        cfg_bus.wr_data    <= '0;
        reset_model();

        // reset held, then released once
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_default_timing();
        test_quick_timing();
        test_zero_limits();
        test_full_limits();
        test_crossed_limits();
        test_receiver_hold();
        test_steady_stream();

        // everything accepted and answered; keep clocking to catch stray words
        wait_results_done();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tmqs_pkg.sv
rtl/core/tmqs_cmd_if.sv
rtl/core/tmqs_rsp_if.sv
rtl/core/tmqs_cfg_if.sv
rtl/core/tmqs_dwell.sv
rtl/core/timed_message_queue_scheduler.sv
tb/tb.sv
